>>> src/dvru_pkg.sv
// ----------------------------------------------------------------------------
// dvru_pkg: shared types and constants for the route update block
// Status codes, op codes, controller states, command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package dvru_pkg;

    localparam int NUM_DIRECT_DEF = 8;
    localparam int NUM_ROUTES_DEF = 64;
    localparam logic [31:0] INF_RESET = 32'd16;

    localparam logic [1:0] OP_ADV    = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [3:0] ST_NO_DIRECT = 4'd0;
    localparam logic [3:0] ST_IMPROVED  = 4'd1;
    localparam logic [3:0] ST_REFRESHED = 4'd2;
    localparam logic [3:0] ST_UNCHANGED = 4'd3;
    localparam logic [3:0] ST_INSERTED  = 4'd4;
    localparam logic [3:0] ST_RT_FULL   = 4'd5;
    localparam logic [3:0] ST_LOADED    = 4'd6;
    localparam logic [3:0] ST_READ      = 4'd7;
    localparam logic [3:0] ST_DIR_FULL  = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE, S_DSCAN, S_DWAIT, S_RSCAN, S_RWAIT, S_UPDATE, S_RDOUT, S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture input item
        logic dscan_start; // clear direct scan counter
        logic dscan_step;  // compare current direct entry, advance
        logic rscan_start;
        logic rscan_step;
        logic rd_issue;    // issue memory read at current route pointer
        logic do_update;   // apply the item's write
        logic capture_out; // register result fields
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic dscan_end;   // direct scan exhausted
        logic dhit;        // direct entry covers sender
        logic rscan_end;
        logic rhit;
    } t_stat;

    function automatic logic [31:0] net_mask(input logic [5:0] p);
        logic [31:0] m;
        if (p == 6'd0) m = 32'd0;
        else if (p >= 6'd32) m = 32'hFFFF_FFFF;
        else m = 32'hFFFF_FFFF << (6'd32 - p);
        return m;
    endfunction

endpackage
`default_nettype wire

>>> src/dvru_ctrl.sv
// ----------------------------------------------------------------------------
// dvru_ctrl: sequencer
// Walks direct scan, route scan, update and output for one item.
// ----------------------------------------------------------------------------
`default_nettype none
module dvru_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_out_free,
    input  wire dvru_pkg::t_stat i_stat,
    output dvru_pkg::t_cmd     o_cmd,
    output logic               o_ready,
    output logic               o_done
);
    dvru_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvru_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dvru_pkg::S_IDLE: begin
                if (i_start) n_state = dvru_pkg::S_DSCAN;
            end
            dvru_pkg::S_DSCAN: begin
                if (i_stat.op == dvru_pkg::OP_ADV) n_state = dvru_pkg::S_DWAIT;
                else n_state = dvru_pkg::S_UPDATE;
            end
            dvru_pkg::S_DWAIT: begin
                if (i_stat.dscan_end) n_state = dvru_pkg::S_UPDATE;
                else if (i_stat.dhit) n_state = dvru_pkg::S_RSCAN;
            end
            dvru_pkg::S_RSCAN: n_state = dvru_pkg::S_RWAIT;
            dvru_pkg::S_RWAIT: begin
                if (i_stat.rscan_end || i_stat.rhit) n_state = dvru_pkg::S_UPDATE;
            end
            dvru_pkg::S_UPDATE: n_state = dvru_pkg::S_RDOUT;
            dvru_pkg::S_RDOUT:  n_state = dvru_pkg::S_DONE;
            dvru_pkg::S_DONE: begin
                if (i_out_free) n_state = dvru_pkg::S_IDLE;
            end
            default: n_state = dvru_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            dvru_pkg::S_IDLE: begin
                o_ready = 1'b1;
                o_cmd.load_item = i_start;
            end
            dvru_pkg::S_DSCAN: begin
                o_cmd.dscan_start = 1'b1;
                o_cmd.rscan_start = 1'b1;
            end
            dvru_pkg::S_DWAIT: begin
                o_cmd.dscan_step = ~(i_stat.dscan_end | i_stat.dhit);
            end
            dvru_pkg::S_RSCAN: o_cmd.rd_issue = 1'b1;
            dvru_pkg::S_RWAIT: begin
                if (!(i_stat.rscan_end || i_stat.rhit)) begin
                    o_cmd.rscan_step = 1'b1;
                    o_cmd.rd_issue   = 1'b1;
                end
            end
            dvru_pkg::S_UPDATE: o_cmd.do_update = 1'b1;
            dvru_pkg::S_RDOUT: o_cmd.rd_issue = 1'b1;
            dvru_pkg::S_DONE: begin
                o_cmd.capture_out = i_out_free;
                o_done = i_out_free;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> src/dvru_dp.sv
// ----------------------------------------------------------------------------
// dvru_dp: datapath
// Direct store in flops, route table in RAM, scan pointers, result fields.
// ----------------------------------------------------------------------------
`default_nettype none
module dvru_dp #(
    parameter int NUM_DIRECT = dvru_pkg::NUM_DIRECT_DEF,
    parameter int NUM_ROUTES = dvru_pkg::NUM_ROUTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    input  wire dvru_pkg::t_cmd i_cmd,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_sender,
    input  wire logic [31:0] i_net,
    input  wire logic [5:0]  i_pfx,
    input  wire logic [31:0] i_dist,
    input  wire logic [31:0] i_rnd,
    input  wire logic [5:0]  i_idx,
    output dvru_pkg::t_stat  o_stat,
    output logic [154:0]     o_result
);
    localparam int DW = (NUM_DIRECT > 1) ? $clog2(NUM_DIRECT) : 1;
    localparam int RW = $clog2(NUM_ROUTES);
    localparam int DC = $clog2(NUM_DIRECT + 1);
    localparam int RC = $clog2(NUM_ROUTES + 1);
    // route word: net, prefix, cost, via, direct flag, last round
    localparam int EW = 32 + 6 + 32 + 32 + 1 + 32;

    logic [31:0] r_inf;
    logic [1:0]  r_op;
    logic [31:0] r_sender, r_net, r_dist, r_rnd;
    logic [5:0]  r_pfx, r_idx;

    logic [31:0] r_dnet [NUM_DIRECT];
    logic [5:0]  r_dpfx [NUM_DIRECT];
    logic [31:0] r_dcost [NUM_DIRECT];
    logic [31:0] r_dround [NUM_DIRECT];
    logic [DC-1:0] r_dtotal;
    logic [RC-1:0] r_rtotal;

    logic [EW-1:0] r_mem [NUM_ROUTES];
    logic [EW-1:0] r_rdata;

    logic [DC-1:0] r_dptr;
    logic [RC-1:0] r_rptr;   // address issued
    logic [RC-1:0] r_rcur;   // address of r_rdata during route scan
    logic [RC-1:0] r_tgt;    // route touched by update
    logic          r_tgt_ok;
    logic [3:0]    r_status;
    logic [31:0]   r_sum;

    logic [DW-1:0] w_dsel;
    logic [RW-1:0] w_raddr;
    logic [31:0]   w_mask_d, w_mask_r;
    logic [31:0]   e_net, e_cost, e_via, e_round;
    logic [5:0]    e_pfx;
    logic          e_dir;
    logic [32:0]   w_sum;

    logic          wr_en;
    logic [EW-1:0] wr_data;
    logic [3:0]    n_status;
    logic [RC-1:0] n_tgt;
    logic          n_tgt_ok;

    assign w_dsel = r_dptr[DW-1:0];
    assign {e_net, e_pfx, e_cost, e_via, e_dir, e_round} = r_rdata;
    assign w_mask_d = dvru_pkg::net_mask(r_dpfx[w_dsel]);
    assign w_mask_r = dvru_pkg::net_mask(e_pfx);

    assign o_stat.op        = r_op;
    assign o_stat.dscan_end = (r_dptr >= r_dtotal);
    assign o_stat.dhit      = ((r_dnet[w_dsel] & w_mask_d) == (r_sender & w_mask_d));
    assign o_stat.rscan_end = (r_rcur >= r_rtotal);
    assign o_stat.rhit      = (e_pfx == r_pfx) && ((e_net & w_mask_r) == (r_net & w_mask_r));

    assign w_sum = {1'b0, r_dcost[w_dsel]} + {1'b0, r_dist};

    // read address: route pointer during scan, touched/read route for output
    always_comb begin
        if (i_cmd.rscan_step) w_raddr = r_rptr[RW-1:0] + RW'(1);
        else if (i_cmd.do_update || r_tgt_ok) w_raddr = r_tgt[RW-1:0];
        else w_raddr = r_rptr[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) r_rdata <= r_mem[w_raddr];
        if (wr_en) r_mem[n_tgt[RW-1:0]] <= wr_data;
    end

    always_comb begin
        wr_en    = 1'b0;
        wr_data  = r_rdata;
        n_status = dvru_pkg::ST_NO_DIRECT;
        n_tgt    = r_rcur;
        n_tgt_ok = 1'b0;
        if (r_op == dvru_pkg::OP_ADV) begin
            if (!o_stat.dscan_end) begin
                if (!o_stat.rscan_end) begin
                    n_tgt_ok = 1'b1;
                    if (r_sum < e_cost) begin
                        wr_en = 1'b1;
                        wr_data = {e_net, e_pfx, r_sum, r_sender, 1'b0, r_rnd};
                        n_status = dvru_pkg::ST_IMPROVED;
                    end else if (!e_dir && e_via == r_sender) begin
                        wr_en = 1'b1;
                        wr_data = {e_net, e_pfx, (r_dist >= r_inf) ? r_dist : r_sum,
                                   e_via, e_dir, r_rnd};
                        n_status = dvru_pkg::ST_REFRESHED;
                    end else begin
                        n_status = dvru_pkg::ST_UNCHANGED;
                    end
                end else if (r_rtotal < RC'(NUM_ROUTES)) begin
                    n_tgt = r_rtotal;
                    n_tgt_ok = 1'b1;
                    wr_en = 1'b1;
                    wr_data = {r_net, r_pfx, r_sum, r_sender, 1'b0, r_rnd};
                    n_status = dvru_pkg::ST_INSERTED;
                end else begin
                    n_status = dvru_pkg::ST_RT_FULL;
                end
            end
        end else if (r_op == dvru_pkg::OP_LOAD) begin
            if (r_dtotal >= DC'(NUM_DIRECT)) n_status = dvru_pkg::ST_DIR_FULL;
            else if (r_rtotal >= RC'(NUM_ROUTES)) n_status = dvru_pkg::ST_RT_FULL;
            else begin
                n_tgt = r_rtotal;
                n_tgt_ok = 1'b1;
                wr_en = 1'b1;
                wr_data = {r_net, r_pfx, r_dist, 32'd0, 1'b1, r_rnd};
                n_status = dvru_pkg::ST_LOADED;
            end
        end else if (r_op == dvru_pkg::OP_READ) begin
            n_status = dvru_pkg::ST_READ;
            n_tgt = RC'(r_idx);
            n_tgt_ok = (RC'(r_idx) < r_rtotal) && (32'(r_idx) < 32'(NUM_ROUTES));
        end
        if (!i_cmd.do_update) wr_en = 1'b0;
    end

    logic [DC-1:0] r_dhit_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inf    <= dvru_pkg::INF_RESET;
            r_dtotal <= '0;
            r_rtotal <= '0;
            r_tgt_ok <= 1'b0;
        end else begin
            if (i_cfg_we) r_inf <= i_cfg_data;
            if (i_cmd.load_item) r_tgt_ok <= 1'b0;
            if (i_cmd.do_update) begin
                r_tgt_ok <= n_tgt_ok;
                if (n_status == dvru_pkg::ST_INSERTED) r_rtotal <= r_rtotal + RC'(1);
                if (n_status == dvru_pkg::ST_LOADED) begin
                    r_rtotal <= r_rtotal + RC'(1);
                    r_dtotal <= r_dtotal + DC'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op <= i_op; r_sender <= i_sender; r_net <= i_net; r_pfx <= i_pfx;
            r_dist <= i_dist; r_rnd <= i_rnd; r_idx <= i_idx;
        end
        if (i_cmd.dscan_start) r_dptr <= '0;
        if (i_cmd.dscan_step) r_dptr <= r_dptr + DC'(1);
        if (i_cmd.rscan_start) begin
            r_rptr <= '0;
            r_rcur <= '0;
        end
        if (i_cmd.rscan_step) r_rptr <= r_rptr + RC'(1);
        if (i_cmd.rd_issue && !i_cmd.do_update) r_rcur <= i_cmd.rscan_step ?
            r_rptr + RC'(1) : r_rptr;
        r_sum <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        if (i_cmd.do_update) begin
            r_status <= n_status;
            r_tgt <= n_tgt;
            r_dhit_idx <= r_dptr;
            if (r_op == dvru_pkg::OP_ADV && !o_stat.dscan_end)
                r_dround[w_dsel] <= r_rnd;
            if (n_status == dvru_pkg::ST_LOADED) begin
                r_dnet[r_dtotal[DW-1:0]]   <= r_net;
                r_dpfx[r_dtotal[DW-1:0]]   <= r_pfx;
                r_dcost[r_dtotal[DW-1:0]]  <= r_dist;
                r_dround[r_dtotal[DW-1:0]] <= r_rnd;
            end
        end
    end

    // result: status, direct idx, route idx, net, pfx, cost, via, dir, round, total
    logic [2:0]  w_didx;
    logic [5:0]  w_ridx;
    logic        w_has_d, w_has_r;
    logic [EW-1:0] w_ent;

    assign w_didx = (r_status == dvru_pkg::ST_LOADED) ? 3'(r_dtotal - DC'(1))
                                                      : 3'(r_dhit_idx);
    assign w_has_d = (r_status != dvru_pkg::ST_NO_DIRECT) && (r_status != dvru_pkg::ST_READ)
                     && (r_status != dvru_pkg::ST_DIR_FULL)
                     && !(r_status == dvru_pkg::ST_RT_FULL && r_op == dvru_pkg::OP_LOAD);
    assign w_has_r = r_tgt_ok;
    assign w_ridx = (w_has_r || r_status == dvru_pkg::ST_READ) ? 6'(r_tgt) : 6'd0;
    assign w_ent = w_has_r ? r_rdata : '0;

    assign o_result = {7'(r_rtotal), w_ent[0 +: 32], w_ent[32], w_ent[33 +: 32],
                       w_ent[65 +: 32], w_ent[97 +: 6], w_ent[103 +: 32],
                       w_ridx, w_has_d ? w_didx : 3'd0, r_status};
endmodule
`default_nettype wire

>>> src/distance_vector_route_update_top.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update_top: distance-vector route table update
// Direct network store, route table, one result per item on a stream port.
// ----------------------------------------------------------------------------
// Sequence: an advertisement compares direct entries, then routes (the route scan
// runs only after a direct hit), one per cycle, each scan stopping at a hit or past
// its total; then update, read-back and output. Load, read and other ops skip scans.
// Throughput: one item at a time; the route table RAM port sets the scan rate.
// Reset (i_rst_n low, synchronous): totals cleared, infinity back to 16.
// Table entries hold no reset value; their contents are used only below their totals.
`default_nettype none
module distance_vector_route_update_top #(
    parameter int NUM_DIRECT = dvru_pkg::NUM_DIRECT_DEF,
    parameter int NUM_ROUTES = dvru_pkg::NUM_ROUTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_data,      // infinity_distance
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // op[1:0] sender[33:2] net[65:34] prefix[71:66] distance[103:72]
    // round[135:104] entry_index[141:136], zero pad to 144
    input  wire logic [143:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[3:0] direct_index[6:4] route_index[12:7] route_network[44:13]
    // route_prefix[50:45] route_cost[82:51] route_next_hop[114:83]
    // route_is_direct[115] route_last_seen[147:116] route_total[154:148], pad to 160
    output logic [159:0]      m_axis_tdata
);
    dvru_pkg::t_cmd  w_cmd;
    dvru_pkg::t_stat w_stat;
    logic            w_done;
    logic [154:0]    w_res;
    logic            r_ovalid;
    logic [154:0]    r_odata;

    dvru_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid && s_axis_tready),
        .i_out_free(!r_ovalid || m_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_ready(s_axis_tready), .o_done(w_done)
    );

    dvru_dp #(.NUM_DIRECT(NUM_DIRECT), .NUM_ROUTES(NUM_ROUTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .i_cmd(w_cmd),
        .i_op(s_axis_tdata[1:0]), .i_sender(s_axis_tdata[33:2]),
        .i_net(s_axis_tdata[65:34]), .i_pfx(s_axis_tdata[71:66]),
        .i_dist(s_axis_tdata[103:72]), .i_rnd(s_axis_tdata[135:104]),
        .i_idx(s_axis_tdata[141:136]), .o_stat(w_stat), .o_result(w_res)
    );

    // output register; result held until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) r_odata <= w_res;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_odata};
endmodule
`default_nettype wire

>>> sim/route_update_checker.sv
// ----------------------------------------------------------------------------
// route_update_checker: predicts and checks route update results
// Watches the item streams and the infinity register write, keeps its own copy
// of the direct store and routing table, and compares each result item.
// ----------------------------------------------------------------------------
`default_nettype none
module route_update_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [143:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [159:0] m_axis_tdata,
    output int                o_errors,
    output int                o_pending,
    output int                o_results
);

    typedef struct packed {
        logic [6:0]  total;
        logic [31:0] last_seen;
        logic        is_direct;
        logic [31:0] next_hop;
        logic [31:0] cost;
        logic [5:0]  prefix;
        logic [31:0] network;
        logic [5:0]  route_idx;
        logic [2:0]  direct_idx;
        logic [3:0]  status;
    } t_route_result;

    logic [31:0] infinity;
    logic [31:0] dnet [8];
    logic [5:0]  dpfx [8];
    logic [31:0] dcost [8];
    logic [31:0] dround [8];
    int          dcount;
    logic [31:0] rnet [64];
    logic [5:0]  rpfx [64];
    logic [31:0] rcost [64];
    logic [31:0] rvia [64];
    logic        rdir [64];
    logic [31:0] rround [64];
    int          rcount;
    t_route_result expected_q [$];

    function automatic logic covers(logic [31:0] net, logic [5:0] p, logic [31:0] a);
        logic [31:0] m;
        if (p == 0) m = '0;
        else if (p >= 32) m = '1;
        else m = 32'hFFFF_FFFF << (32 - p);
        return (net & m) == (a & m);
    endfunction

    function automatic t_route_result fill_route(t_route_result r, int j);
        r.route_idx = j[5:0];
        r.network = rnet[j];
        r.prefix = rpfx[j];
        r.cost = rcost[j];
        r.next_hop = rvia[j];
        r.is_direct = rdir[j];
        r.last_seen = rround[j];
        return r;
    endfunction

    task automatic predict_route_update(input logic [143:0] d);
        logic [1:0]  op;
        logic [31:0] snd, net, adv_dist, rnd, sum;
        logic [32:0] wide;
        logic [5:0]  pfx, idx;
        int          i, j;
        t_route_result r;
        op = d[1:0]; snd = d[33:2]; net = d[65:34]; pfx = d[71:66];
        adv_dist = d[103:72]; rnd = d[135:104]; idx = d[141:136];
        r = '0;
        if (op == dvru_pkg::OP_ADV) begin
            for (i = 0; i < dcount; i++)
                if (covers(dnet[i], dpfx[i], snd)) break;
            if (i < dcount) begin
                wide = {1'b0, dcost[i]} + {1'b0, adv_dist};
                sum = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
                dround[i] = rnd;
                r.direct_idx = i[2:0];
                for (j = 0; j < rcount; j++)
                    if (rpfx[j] == pfx && covers(rnet[j], rpfx[j], net)) break;
                if (j < rcount) begin
                    if (sum < rcost[j]) begin
                        rcost[j] = sum; rvia[j] = snd; rdir[j] = 0; rround[j] = rnd;
                        r.status = dvru_pkg::ST_IMPROVED;
                    end else if (!rdir[j] && rvia[j] == snd) begin
                        rround[j] = rnd;
                        rcost[j] = (adv_dist >= infinity) ? adv_dist : sum;
                        r.status = dvru_pkg::ST_REFRESHED;
                    end else begin
                        r.status = dvru_pkg::ST_UNCHANGED;
                    end
                    r = fill_route(r, j);
                end else if (rcount < 64) begin
                    j = rcount++;
                    rnet[j] = net; rpfx[j] = pfx; rcost[j] = sum; rvia[j] = snd;
                    rdir[j] = 0; rround[j] = rnd;
                    r.status = dvru_pkg::ST_INSERTED;
                    r = fill_route(r, j);
                end else begin
                    r.status = dvru_pkg::ST_RT_FULL;
                end
            end else begin
                r.status = dvru_pkg::ST_NO_DIRECT;
            end
        end else if (op == dvru_pkg::OP_LOAD) begin
            if (dcount >= 8) r.status = dvru_pkg::ST_DIR_FULL;
            else if (rcount >= 64) r.status = dvru_pkg::ST_RT_FULL;
            else begin
                i = dcount++;
                dnet[i] = net; dpfx[i] = pfx; dcost[i] = adv_dist; dround[i] = rnd;
                j = rcount++;
                rnet[j] = net; rpfx[j] = pfx; rcost[j] = adv_dist; rvia[j] = '0;
                rdir[j] = 1; rround[j] = rnd;
                r.status = dvru_pkg::ST_LOADED;
                r.direct_idx = i[2:0];
                r = fill_route(r, j);
            end
        end else if (op == dvru_pkg::OP_READ) begin
            r.status = dvru_pkg::ST_READ;
            r.route_idx = idx;
            if (idx < rcount) r = fill_route(r, idx);
        end else begin
            r.status = dvru_pkg::ST_NO_DIRECT;
        end
        r.total = rcount[6:0];
        expected_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_route_result got, want;
        if (!i_rst_n) begin
            infinity = 32'd16;
            dcount = 0;
            rcount = 0;
        end else begin
            if (i_cfg_we) infinity = i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[154:0];
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result item %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want || m_axis_tdata[159:155] !== '0) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display({"mismatch st %0d/%0d di %0d/%0d ri %0d/%0d",
                                      " net %h/%h pfx %0d/%0d cost %h/%h hop %h/%h",
                                      " dir %b/%b seen %h/%h tot %0d/%0d"},
                                want.status, got.status, want.direct_idx, got.direct_idx,
                                want.route_idx, got.route_idx, want.network, got.network,
                                want.prefix, got.prefix, want.cost, got.cost,
                                want.next_hop, got.next_hop, want.is_direct, got.is_direct,
                                want.last_seen, got.last_seen, want.total, got.total);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_route_update(s_axis_tdata);
        end
        o_pending <= expected_q.size();
    end

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
        infinity = 32'd16;
        dcount = 0;
        rcount = 0;
    end

endmodule
`default_nettype wire

>>> sim/tb_distance_vector_route_update_top.sv
// ----------------------------------------------------------------------------
// tb_distance_vector_route_update_top: route update block testbench
// Directed then random items (loads, advertisements, reads) in table
// fill cycles with bursty input and stalled output; a checker compares all.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_distance_vector_route_update_top;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    wire          s_axis_tready;
    logic [143:0] s_axis_tdata;   // op sender net prefix distance round index
    wire          m_axis_tvalid;
    logic         m_axis_tready;
    wire  [159:0] m_axis_tdata;   // status .. route_total, see block ports
    int           errors, pending, results;
    int           cycles;
    int           gap_left;       // sender idle cycles still to spend
    logic [31:0]  nets [8];       // direct networks loaded so far
    logic [5:0]   pfxs [8];
    int           nloaded;

    localparam int CYCLE_LIMIT = 2_000_000;

    distance_vector_route_update_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    route_update_checker CHK (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: stalls at random, with a stall-free stretch now and then.
    always @(posedge i_clk) begin
        if (cycles % 4000 < 600) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Present one item; bursty: sometimes idle a random gap first.
    task automatic send_item(input logic [1:0] op, input logic [31:0] snd,
                             input logic [31:0] net, input logic [5:0] pfx,
                             input logic [31:0] adv_dist, input logic [31:0] rnd,
                             input logic [5:0] idx);
        if (gap_left == 0 && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 40);
        while (gap_left > 0) begin
            @(posedge i_clk);
            s_axis_tvalid <= 1'b0;
            gap_left--;
        end
        @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, idx, rnd, adv_dist, pfx, net, snd, op};
        do @(posedge i_clk); while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait for all results, then let any in-flight work settle.
    task automatic drain;
        int n;
        n = 0;
        @(posedge i_clk);
        while (pending != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_infinity(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_dist();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom();
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    // An address inside loaded direct network k.
    function automatic logic [31:0] inside_net(int k);
        logic [31:0] m;
        m = (pfxs[k] == 0) ? 32'd0 : (pfxs[k] >= 32) ? '1 : 32'hFFFF_FFFF << (32 - pfxs[k]);
        return (nets[k] & m) | ($urandom() & ~m);
    endfunction

    int          sent;
    int          ph;
    logic [31:0] infs [5] = '{32'd16, 32'd0, 32'hFFFF_FFFF, 32'd8, 32'd1000};

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_data = '0;
        s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
        cycles = 0; gap_left = 0; nloaded = 0; sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no direct match, reads past total, unknown op, loads with
        // prefix extremes, improve/refresh/unchanged, saturating sums.
        send_item(dvru_pkg::OP_ADV, 32'h0A00_0001, 32'hC0A8_0000, 6'd24, 32'd1, 32'd1, 6'd0);
        send_item(dvru_pkg::OP_READ, '0, '0, 6'd0, '0, '0, 6'd63);
        send_item(dvru_pkg::OP_UNUSED, '1, '1, 6'd63, '1, '1, 6'd63);
        send_item(dvru_pkg::OP_LOAD, '0, 32'h0A00_0000, 6'd8, 32'd1, 32'd5, 6'd0);
        send_item(dvru_pkg::OP_LOAD, '0, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, '1, 6'd0);
        send_item(dvru_pkg::OP_LOAD, '0, 32'h5555_AAAA, 6'd32, 32'd3, 32'd0, 6'd0);
        send_item(dvru_pkg::OP_ADV, 32'h0A01_0203, 32'h1400_0000, 6'd16, 32'd10, 32'd7, 6'd0);
        send_item(dvru_pkg::OP_ADV, 32'h0A01_0203, 32'h1400_0000, 6'd16, 32'd2, 32'd8, 6'd0);
        send_item(dvru_pkg::OP_ADV, 32'h0A01_0203, 32'h1400_0000, 6'd16, 32'd20, 32'd9, 6'd0);
        send_item(dvru_pkg::OP_ADV, 32'h0A09_0909, 32'h1400_0000, 6'd16, 32'd50, 32'd9, 6'd0);
        send_item(dvru_pkg::OP_ADV, 32'hFFFF_FFFF, 32'h1E00_0000, 6'd0, 32'hFFFF_FFFF, '1,
                  6'd0);
        send_item(dvru_pkg::OP_ADV, 32'h0A00_0001, 32'h0A00_0000, 6'd8, 32'd0, 32'd3, 6'd0);
        send_item(dvru_pkg::OP_READ, '0, '0, 6'd0, '0, '0, 6'd0);
        send_item(dvru_pkg::OP_READ, '0, '0, 6'd0, '0, '0, 6'd4);
        drain();
        write_infinity(32'hFFFF_FFFF);
        send_item(dvru_pkg::OP_ADV, 32'h0A01_0203, 32'h1400_0000, 6'd16, 32'hFFFF_FFF0,
                  32'd11, 6'd0);
        drain();

        // Random phases: each starts with an infinity write and no reset; the tables persist,
        // so the routing table fills up and direct store saturates too.
        nets[0] = 32'h0A00_0000; pfxs[0] = 6'd8;
        nets[1] = 32'hFFFF_FFFF; pfxs[1] = 6'd63;
        nets[2] = 32'h5555_AAAA; pfxs[2] = 6'd32;
        nloaded = 3;
        for (ph = 0; ph < 5; ph++) begin
            write_infinity(infs[ph]);
            repeat (400) begin
                int k, r;
                logic [5:0] p;
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    p = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(4, 24));
                    send_item(dvru_pkg::OP_LOAD, $urandom(), $urandom(), p, rand_dist(),
                              $urandom(), 6'd0);
                    if (nloaded < 8) begin
                        nets[nloaded] = s_axis_tdata[65:34];
                        pfxs[nloaded] = p;
                        nloaded++;
                    end
                end else if (r < 70) begin
                    k = $urandom_range(0, nloaded - 1);
                    p = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'd24;
                    send_item(dvru_pkg::OP_ADV, inside_net(k),
                              {8'd20, 12'd0, 4'($urandom_range(0, 15)), 8'd0},
                              p, rand_dist(), $urandom(), 6'd0);
                end else if (r < 80) begin
                    send_item(dvru_pkg::OP_ADV, $urandom(), $urandom(),
                              6'($urandom_range(0, 63)), $urandom(), $urandom(),
                              6'($urandom_range(0, 63)));
                end else if (r < 97) begin
                    send_item(dvru_pkg::OP_READ, $urandom(), $urandom(),
                              6'($urandom_range(0, 63)), $urandom(), $urandom(),
                              6'($urandom_range(0, 63)));
                end else begin
                    send_item(dvru_pkg::OP_UNUSED, $urandom(), $urandom(),
                              6'($urandom_range(0, 63)), $urandom(), $urandom(),
                              6'($urandom_range(0, 63)));
                end
                sent++;
            end
            // Sender holds off until everything is back.
            drain();
        end

        $display("covered %0d random items over 5 infinity settings, %0d results checked",
                 sent, results);
        $display("direct store and routing table filled past capacity");
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
src/dvru_pkg.sv
src/dvru_ctrl.sv
src/dvru_dp.sv
src/distance_vector_route_update_top.sv
sim/route_update_checker.sv
sim/tb_distance_vector_route_update_top.sv
